// File: rtl/pea_pkg.sv
// ----------------------------------------------------------------------------
// pea_pkg: shared types and constants for the permission expression applier
// Parser state and result records, operator codes, character codes and class/action masks.
// ----------------------------------------------------------------------------
package pea_pkg;

  localparam int MaxExprLen = 1024;
  localparam int PosLimInt  = (MaxExprLen - 1 > 1023) ? 1023 : (MaxExprLen - 1);
  localparam logic [9:0] POS_LIMIT = 10'(PosLimInt);

  typedef enum logic [1:0] {
    OP_ASSIGN = 2'd0,
    OP_OR     = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_AND    = 2'd3
  } pea_op_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  // Class masks
  localparam logic [11:0] CLS_U = 12'o5700;
  localparam logic [11:0] CLS_G = 12'o3070;
  localparam logic [11:0] CLS_O = 12'o1007;
  localparam logic [11:0] CLS_A = 12'o7777;

  // Action bit sets
  localparam logic [11:0] ACT_R = 12'o0444;
  localparam logic [11:0] ACT_W = 12'o0222;
  localparam logic [11:0] ACT_X = 12'o0111;
  localparam logic [11:0] ACT_S = 12'o6000;
  localparam logic [11:0] ACT_T = 12'o1000;

  typedef struct packed {
    logic [11:0] mode;
    logic [11:0] cls;
    logic [11:0] bits;
    logic [11:0] oct;
    pea_op_t     op;
    logic        act;
    logic        halted;
    logic [9:0]  pos;
  } pea_state_t;

  typedef struct packed {
    logic        emit;
    logic [11:0] mode;
    logic [9:0]  pos;
    logic        bad;
  } pea_result_t;

endpackage

// File: rtl/pea_step.sv
// ----------------------------------------------------------------------------
// pea_step: one-character parser step
// Decodes one character against the parser state and forms the next state
// and the stop result.
// ----------------------------------------------------------------------------
module pea_step (
  input  pea_pkg::pea_state_t  st_i,
  input  logic [11:0]          start_mode_i,
  input  logic                 first_i,
  input  logic [7:0]           ch_i,
  output pea_pkg::pea_state_t  st_o,
  output pea_pkg::pea_result_t res_o
);
  import pea_pkg::*;

  function automatic pea_state_t clear_term(pea_state_t s);
    pea_state_t r;
    r      = s;
    r.cls  = '0;
    r.bits = '0;
    r.oct  = '0;
    r.op   = OP_ASSIGN;
    r.act  = 1'b0;
    return r;
  endfunction

  function automatic logic [11:0] apply_term(pea_state_t s);
    logic [11:0] set;
    logic [11:0] m;
    set = (s.cls != '0) ? (s.bits & s.cls) : s.bits;
    case (s.op)
      OP_OR:    m = s.mode | set;
      OP_CLEAR: m = s.mode & ~set;
      OP_AND:   m = s.mode & set;
      default:  m = (s.mode & ~s.cls) | set;
    endcase
    return m;
  endfunction

  pea_state_t s;
  logic       adv;
  logic       taken;

  always_comb begin
    s     = st_i;
    adv   = 1'b0;
    taken = 1'b0;
    res_o = '0;
    if (first_i) begin
      s        = clear_term(st_i);
      s.mode   = start_mode_i;
      s.halted = 1'b0;
      s.pos    = '0;
    end
    if (first_i || !st_i.halted) begin
      // class part: letters and an optional operator
      if (!s.act) begin
        taken = 1'b1;
        case (ch_i) inside
          CH_U: s.cls = s.cls | CLS_U;
          CH_G: s.cls = s.cls | CLS_G;
          CH_O: s.cls = s.cls | CLS_O;
          CH_A: s.cls = CLS_A;
          CH_EQ: begin
            s.op  = OP_ASSIGN;
            s.act = 1'b1;
          end
          CH_PLUS, CH_BAR: begin
            s.op  = OP_OR;
            s.act = 1'b1;
          end
          CH_MINUS: begin
            s.op  = OP_CLEAR;
            s.act = 1'b1;
          end
          CH_AMP: begin
            s.op  = OP_AND;
            s.act = 1'b1;
          end
          default: begin
            // no operator: fall into the action part with assign
            s.op  = OP_ASSIGN;
            s.act = 1'b1;
            taken = 1'b0;
          end
        endcase
        adv = taken;
      end
      if (!taken) begin
        if (ch_i >= CH_ZERO && ch_i <= CH_SEVEN) begin
          s.oct = {s.oct[8:0], ch_i[2:0]};
          adv   = 1'b1;
        end else begin
          s.bits = s.bits | s.oct;
          s.oct  = '0;
          case (ch_i)
            CH_R: begin s.bits = s.bits | ACT_R; adv = 1'b1; end
            CH_W: begin s.bits = s.bits | ACT_W; adv = 1'b1; end
            CH_X: begin s.bits = s.bits | ACT_X; adv = 1'b1; end
            CH_S: begin s.bits = s.bits | ACT_S; adv = 1'b1; end
            CH_T: begin s.bits = s.bits | ACT_T; adv = 1'b1; end
            CH_COMMA: begin
              s.mode = apply_term(s);
              s      = clear_term(s);
              adv    = 1'b1;
            end
            CH_NUL: begin
              s.mode    = apply_term(s);
              s.halted  = 1'b1;
              res_o.emit = 1'b1;
              res_o.mode = s.mode;
              res_o.pos  = s.pos;
              res_o.bad  = 1'b0;
            end
            default: begin
              s.halted  = 1'b1;
              res_o.emit = 1'b1;
              res_o.mode = s.mode;
              res_o.pos  = s.pos;
              res_o.bad  = 1'b1;
            end
          endcase
        end
      end
      if (adv) begin
        s.pos = (s.pos < POS_LIMIT) ? (s.pos + 10'd1) : POS_LIMIT;
      end
    end
    st_o = s;
  end

endmodule

// File: rtl/permission_expression_applier.sv
// ----------------------------------------------------------------------------
// permission_expression_applier: symbolic permission expression parser
// Applies a comma-joined list of [ugoa]*[-&+|=]?[rwxst0-7]* terms to a 12-bit
// mode, one character per beat, and reports the mode on NUL or a bad char.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                   | tuser
//  --------+-----+-----------------------------------------+-------------
//  in_     | in  | [11:0] start_mode, [19:12] ch           | first_char
//  out_    | out | [11:0] mode_out, [21:12] stop_offset    | bad_char
//
//  One character per cycle while no result waits on out_: an accepted beat
//  is held in the input register until the step may run, then the parser
//  step updates the state and, on a stop, loads the result register.
//  The input register advances whenever the result register is empty or
//  being drained, so back-pressure on out_ stalls in_ only while a result
//  waits. Reset (rst_n low, synchronous) empties both registers and leaves
//  the parser halted until a beat with first_char set.
//
module permission_expression_applier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] start_mode, [19:12] ch, [23:20] zero
  input  logic        in_tuser,   // [0] first_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [11:0] mode_out, [21:12] stop_offset, [23:22] zero
  output logic        out_tuser   // [0] bad_char
);
  import pea_pkg::*;

  // input register
  logic        in_valid_r;
  logic [11:0] in_mode_r;
  logic [7:0]  in_ch_r;
  logic        in_first_r;

  // parser state and result register
  pea_state_t  st_r;
  pea_state_t  st_nxt;
  pea_result_t res;
  logic        out_valid_r;
  logic [11:0] out_mode_r;
  logic [9:0]  out_pos_r;
  logic        out_bad_r;

  logic out_room;
  logic fire;

  // the step may run when the result register can take whatever it makes
  assign out_room  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_room;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_mode_r  <= in_tdata[11:0];
      in_ch_r    <= in_tdata[19:12];
      in_first_r <= in_tuser;
    end
  end

  pea_step u_step (
    .st_i         (st_r),
    .start_mode_i (in_mode_r),
    .first_i      (in_first_r),
    .ch_i         (in_ch_r),
    .st_o         (st_nxt),
    .res_o        (res)
  );

  // parser state: reset leaves it halted with all terms cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: '0, cls: '0, bits: '0, oct: '0, op: OP_ASSIGN,
                act: 1'b0, halted: 1'b1, pos: '0};
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      out_mode_r <= res.mode;
      out_pos_r  <= res.pos;
      out_bad_r  <= res.bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pos_r, out_mode_r};
  assign out_tuser  = out_bad_r;

`ifndef SYNTHESIS
  // a stop always leaves the parser halted
  a_halt_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.emit |=> st_r.halted)
    else $error("parser not halted after a stop");

  // a halted parser ignores characters until a restart
  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && st_r.halted && !in_first_r |-> !res.emit && st_nxt == st_r)
    else $error("halted parser reacted to a character");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !fire)
    else $error("step ran while a result was waiting");

  // the offset never passes its limit
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pos <= POS_LIMIT)
    else $error("character offset beyond limit");
`endif

endmodule
